[hdl/gbb_pkg.sv]
`default_nettype none
package gbb_pkg;

   // Frame geometry
   localparam int MaxWidth = 1024;
   localparam int ColW     = $clog2(MaxWidth);
   localparam int RowW     = 16;
   localparam int PixW     = 8;
   localparam int CfgWidthW  = 11;
   localparam int CfgHeightW = 16;
   localparam int ResetWidth  = 640;
   localparam int ResetHeight = 480;

   // Configuration port
   localparam int CsrIdxW  = 2;
   localparam int CsrDataW = 16;
   localparam logic [CsrIdxW-1:0] CsrFrameWidth  = 2'd0;
   localparam logic [CsrIdxW-1:0] CsrFrameHeight = 2'd1;

   // Gray weights: (21*r + 72*g + 7*b) / 100, the divide done as *5243 >> 19
   localparam int RedWt   = 21;
   localparam int GreenWt = 72;
   localparam int BlueWt  = 7;
   localparam int WsumW   = 15;
   localparam int GrayMulW  = 13;
   localparam int GrayMul   = 5243;
   localparam int GrayShift = 19;

   // 3x3 mean: sum / 9 done as *7282 >> 16
   localparam int SumW      = 12;
   localparam int DivMulW   = 13;
   localparam int DivMul    = 7282;
   localparam int DivShift  = 16;

   // Queue between front and back
   localparam int QDepth = 4;
   localparam int QPtrW  = $clog2(QDepth);

   // One queued pixel: up to two results (blurred neighbor, own border value)
   typedef struct packed {
      logic [SumW-1:0] blur_sum;
      logic [PixW-1:0] gray;
      logic [RowW-1:0] row;
      logic [ColW-1:0] col;
      logic            has_blur;
      logic            has_border;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage
`default_nettype wire

[hdl/gbb_front.sv]
`default_nettype none
module gbb_front import gbb_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_we,
   input  wire logic [CsrIdxW-1:0]  csr_index,
   input  wire logic [CsrDataW-1:0] csr_wdata,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [PixW-1:0]     req_blue,
   input  wire logic [PixW-1:0]     req_green,
   input  wire logic [PixW-1:0]     req_red,
   input  wire qstat_type           q_stat,
   output logic                     q_push,
   output entry_type                q_wdata
);

   localparam int GrayProdW = WsumW + GrayMulW;

   logic                  adv;
   logic                  acc;
   logic [WsumW-1:0]      wsum;
   logic                  is_blur;
   logic                  is_border;
   logic [ColW-1:0]       col_in;
   logic [RowW-1:0]       row_in;
   logic [GrayProdW-1:0]  gray_prod;
   logic [SumW-1:0]       colsum;
   logic [CfgWidthW-1:0]  wd;
   logic [CfgHeightW-1:0] hd;

   logic [ColW-1:0]  last_col_ff;
   logic [RowW-1:0]  last_row_ff;
   logic [ColW-1:0]  col_ff;
   logic [RowW-1:0]  row_ff;

   logic             s1_valid_ff;
   logic [WsumW-1:0] s1_wsum_ff;
   logic [RowW-1:0]  s1_row_ff;
   logic [ColW-1:0]  s1_col_ff;
   logic             s1_blur_ff;
   logic             s1_border_ff;
   logic [PixW-1:0]  s1_rd1_ff;
   logic [PixW-1:0]  s1_rd2_ff;

   logic             s2_valid_ff;
   logic [PixW-1:0]  s2_gray_ff;
   logic [RowW-1:0]  s2_row_ff;
   logic [ColW-1:0]  s2_col_ff;
   logic             s2_blur_ff;
   logic             s2_border_ff;
   logic [PixW-1:0]  s2_rd1_ff;
   logic [PixW-1:0]  s2_rd2_ff;

   logic             s3_valid_ff;
   entry_type        s3_entry_ff;
   logic [SumW-1:0]  colsum_a_ff;
   logic [SumW-1:0]  colsum_b_ff;

   logic [PixW-1:0]  line_one_mem [MaxWidth];
   logic [PixW-1:0]  line_two_mem [MaxWidth];

   assign adv       = !q_stat.full;
   assign req_ready = adv;
   assign acc       = req_valid && adv;

   assign wsum = WsumW'(RedWt)   * WsumW'(req_red)
               + WsumW'(GreenWt) * WsumW'(req_green)
               + WsumW'(BlueWt)  * WsumW'(req_blue);

   assign is_blur   = (row_ff >= RowW'(2)) && (col_ff >= ColW'(2));
   assign is_border = (row_ff == '0) || (row_ff == last_row_ff)
                   || (col_ff == '0) || (col_ff == last_col_ff);

   always_comb begin
      col_in = col_ff + ColW'(1);
      row_in = row_ff;
      if (col_ff == last_col_ff) begin
         col_in = '0;
         row_in = (row_ff == last_row_ff) ? '0 : row_ff + RowW'(1);
      end
   end

   assign wd = csr_wdata[CfgWidthW-1:0];
   assign hd = csr_wdata[CfgHeightW-1:0];

   assign gray_prod = GrayProdW'(s1_wsum_ff) * GrayProdW'(GrayMul);
   assign colsum    = SumW'(s2_rd2_ff) + SumW'(s2_rd1_ff) + SumW'(s2_gray_ff);

   assign q_push  = adv && s3_valid_ff;
   assign q_wdata = s3_entry_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         last_col_ff <= ColW'(ResetWidth - 1);
         last_row_ff <= RowW'(ResetHeight - 1);
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CsrFrameWidth: begin
                  if (wd == '0) begin
                     last_col_ff <= '0;
                  end else if (wd > CfgWidthW'(MaxWidth)) begin
                     last_col_ff <= ColW'(MaxWidth - 1);
                  end else begin
                     last_col_ff <= ColW'(wd - CfgWidthW'(1));
                  end
                  col_ff <= '0;
                  row_ff <= '0;
               end
               CsrFrameHeight: begin
                  last_row_ff <= (hd == '0) ? '0 : RowW'(hd - CfgHeightW'(1));
                  col_ff <= '0;
                  row_ff <= '0;
               end
               default: begin
               end
            endcase
         end else if (acc) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (adv) begin
            s1_valid_ff <= acc;
            s2_valid_ff <= s1_valid_ff;
            // drop pixels that cause no result
            s3_valid_ff <= s2_valid_ff && (s2_blur_ff || s2_border_ff);
         end
      end
   end

   // datapath, line stores and window
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_wsum_ff   <= wsum;
         s1_row_ff    <= row_ff;
         s1_col_ff    <= col_ff;
         s1_blur_ff   <= is_blur;
         s1_border_ff <= is_border;
         s1_rd1_ff    <= line_one_mem[col_ff];
         s1_rd2_ff    <= line_two_mem[col_ff];

         s2_gray_ff   <= gray_prod[GrayShift +: PixW];
         s2_row_ff    <= s1_row_ff;
         s2_col_ff    <= s1_col_ff;
         s2_blur_ff   <= s1_blur_ff;
         s2_border_ff <= s1_border_ff;
         s2_rd1_ff    <= s1_rd1_ff;
         s2_rd2_ff    <= s1_rd2_ff;

         if (s2_valid_ff) begin
            line_one_mem[s2_col_ff] <= s2_gray_ff;
            line_two_mem[s2_col_ff] <= s2_rd1_ff;
            colsum_a_ff <= colsum_b_ff;
            colsum_b_ff <= colsum;
            s3_entry_ff.blur_sum   <= colsum_a_ff + colsum_b_ff + colsum;
            s3_entry_ff.gray       <= s2_gray_ff;
            s3_entry_ff.row        <= s2_row_ff;
            s3_entry_ff.col        <= s2_col_ff;
            s3_entry_ff.has_blur   <= s2_blur_ff;
            s3_entry_ff.has_border <= s2_border_ff;
         end
      end
   end

endmodule
`default_nettype wire

[hdl/gbb_fifo.sv]
`default_nettype none
module gbb_fifo import gbb_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type wdata,
   input  wire logic      pop,
   output entry_type      rdata,
   output qstat_type      stat
);

   entry_type          slot_ff [QDepth];
   logic [QPtrW-1:0]   wr_ptr_ff;
   logic [QPtrW-1:0]   rd_ptr_ff;
   logic [QPtrW:0]     count_ff;

   assign rdata      = slot_ff[rd_ptr_ff];
   assign stat.full  = (count_ff == (QPtrW+1)'(QDepth));
   assign stat.empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPtrW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPtrW'(1);
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + (QPtrW+1)'(1);
            2'b01:   count_ff <= count_ff - (QPtrW+1)'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule
`default_nettype wire

[hdl/gbb_back.sv]
`default_nettype none
module gbb_back import gbb_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire entry_type q_rdata,
   input  wire qstat_type q_stat,
   output logic           q_pop,
   output logic           rsp_valid,
   input  wire logic      rsp_ready,
   output logic [PixW-1:0] rsp_gray_out,
   output logic [RowW-1:0] rsp_out_row,
   output logic [ColW-1:0] rsp_out_col,
   output logic           rsp_run_last
);

   localparam int DivProdW = SumW + DivMulW;

   logic                 out_free;
   logic                 emit;
   logic                 blur_first;
   logic                 split;
   logic                 d_done;
   logic [DivProdW-1:0]  div_prod;

   logic                 d_valid_ff;
   logic                 d_phase_ff;
   entry_type            d_entry_ff;

   logic                 rsp_valid_ff;
   logic [PixW-1:0]      rsp_gray_ff;
   logic [RowW-1:0]      rsp_row_ff;
   logic [ColW-1:0]      rsp_col_ff;
   logic                 rsp_last_ff;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign emit       = d_valid_ff && out_free;
   assign blur_first = d_entry_ff.has_blur && !d_phase_ff;
   assign split      = blur_first && d_entry_ff.has_border;
   assign d_done     = emit && !split;
   assign q_pop      = (!d_valid_ff || d_done) && !q_stat.empty;

   assign div_prod = DivProdW'(d_entry_ff.blur_sum) * DivProdW'(DivMul);

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_gray_out = rsp_gray_ff;
   assign rsp_out_row  = rsp_row_ff;
   assign rsp_out_col  = rsp_col_ff;
   assign rsp_run_last = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff   <= 1'b0;
         d_phase_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            d_valid_ff <= 1'b1;
            d_phase_ff <= 1'b0;
         end else if (d_done) begin
            d_valid_ff <= 1'b0;
         end else if (emit && split) begin
            d_phase_ff <= 1'b1;
         end
         if (out_free) begin
            rsp_valid_ff <= emit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         d_entry_ff <= q_rdata;
      end
      if (emit) begin
         if (blur_first) begin
            rsp_gray_ff <= div_prod[DivShift +: PixW];
            rsp_row_ff  <= d_entry_ff.row - RowW'(1);
            rsp_col_ff  <= d_entry_ff.col - ColW'(1);
            rsp_last_ff <= !d_entry_ff.has_border;
         end else begin
            rsp_gray_ff <= d_entry_ff.gray;
            rsp_row_ff  <= d_entry_ff.row;
            rsp_col_ff  <= d_entry_ff.col;
            rsp_last_ff <= 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

[hdl/gray_box_blur_3x3.sv]
// Pipeline: a request passes s1, s2, s3, the queue, the decode register and
// the output register before its first response. Throughput: one request per
// cycle in unless the queue is full; one response per cycle out while rsp_ready
// is high, and the queue absorbs bursts of pixels with two responses.
// Reset: synchronous, active high; clears counters, pipeline and queue;
// frame size returns to 640x480. Line stores are not cleared.
`default_nettype none
module gray_box_blur_3x3 import gbb_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_we,
   input  wire logic [CsrIdxW-1:0]  csr_index,
   input  wire logic [CsrDataW-1:0] csr_wdata,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [PixW-1:0]     req_blue,
   input  wire logic [PixW-1:0]     req_green,
   input  wire logic [PixW-1:0]     req_red,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [PixW-1:0]          rsp_gray_out,
   output logic [RowW-1:0]          rsp_out_row,
   output logic [ColW-1:0]          rsp_out_col,
   output logic                     rsp_run_last
);

   // Front: count raster position, classify the pixel (blur of the upper-left
   // neighbor, border pass-through, or nothing), convert to gray, keep the two
   // line stores and the running column sums, then push one entry per pixel
   // that yields any response.
   logic      q_push;
   logic      q_pop;
   entry_type q_wdata;
   entry_type q_rdata;
   qstat_type q_stat;

   gbb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_blue  (req_blue),
      .req_green (req_green),
      .req_red   (req_red),
      .q_stat    (q_stat),
      .q_push    (q_push),
      .q_wdata   (q_wdata)
   );

   // Queue: decouple the front from response backpressure.
   gbb_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .pop   (q_pop),
      .rdata (q_rdata),
      .stat  (q_stat)
   );

   // Back: finish the divide by nine and serialize the blurred response
   // ahead of the border response; mark the last one of each request.
   gbb_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_rdata      (q_rdata),
      .q_stat       (q_stat),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_gray_out (rsp_gray_out),
      .rsp_out_row  (rsp_out_row),
      .rsp_out_col  (rsp_out_col),
      .rsp_run_last (rsp_run_last)
   );

`ifndef NO_ASSERTIONS
   // never push into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_stat.full))
      else $error("queue overflow");

   // never pop an empty queue
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(q_pop && q_stat.empty))
      else $error("queue underflow");

   // a non-final response is a blurred pixel, never on row or column zero
   a_blur_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_run_last |-> rsp_out_row != '0 && rsp_out_col != '0)
      else $error("blurred response at frame edge");

   // the second response of a request follows right after the first
   a_pair_back_to_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_run_last |=> rsp_valid)
      else $error("gap inside a response run");
`endif

endmodule
`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
   import gbb_pkg::*;

   // Spare register indexes: writes there must be ignored and must not restart the frame
   localparam logic [CsrIdxW-1:0] CsrSpareA = 2'd2;
   localparam logic [CsrIdxW-1:0] CsrSpareB = 2'd3;

   localparam int ResetCycles = 12;
   localparam int DrainCycles = 12;    // leave headroom for silent pixels
   localparam int HoldCycles  = 100;   // long output hold-off in the pressure test
   localparam int QuietLimit  = 1000;  // cycles with no handshake before giving up

   // One expected response
   typedef struct packed {
      logic [PixW-1:0] gray;
      logic [RowW-1:0] row;
      logic [ColW-1:0] col;
      logic            last;
   } pixel_result_type;

   logic                clock;
   logic                reset;
   logic                csr_we;
   logic [CsrIdxW-1:0]  csr_index;
   logic [CsrDataW-1:0] csr_wdata;
   logic                req_valid;
   logic                req_ready;
   logic [PixW-1:0]     req_blue;
   logic [PixW-1:0]     req_green;
   logic [PixW-1:0]     req_red;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [PixW-1:0]     rsp_gray_out;
   logic [RowW-1:0]     rsp_out_row;
   logic [ColW-1:0]     rsp_out_col;
   logic                rsp_run_last;

   gray_box_blur_3x3 dut (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_blue     (req_blue),
      .req_green    (req_green),
      .req_red      (req_red),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_gray_out (rsp_gray_out),
      .rsp_out_row  (rsp_out_row),
      .rsp_out_col  (rsp_out_col),
      .rsp_run_last (rsp_run_last)
   );

   // ------------------------------------------------------------------
   // Shadow of the block: line stores, window, frame position, geometry
   // ------------------------------------------------------------------
   logic [PixW-1:0]       gray_two_rows_up [MaxWidth];
   logic [PixW-1:0]       gray_one_row_up  [MaxWidth];
   logic [3*PixW-1:0]     window_col [3];
   int unsigned           next_row;
   int unsigned           next_col;
   logic [CfgWidthW-1:0]  width_reg;
   logic [CfgHeightW-1:0] height_reg;

   pixel_result_type expected_q [$];

   int unsigned fail_count;
   int unsigned requests_sent;
   int unsigned responses_checked;
   int unsigned blurs_expected;
   int unsigned config_writes;
   int unsigned quiet_cycles;

   bit hold_request;
   bit hold_active;

   initial begin
      for (int i = 0; i < MaxWidth; i++) begin
         gray_two_rows_up[i] = '0;
         gray_one_row_up[i]  = '0;
      end
      for (int i = 0; i < 3; i++) window_col[i] = '0;
      next_row          = 0;
      next_col          = 0;
      width_reg         = CfgWidthW'(ResetWidth);
      height_reg        = CfgHeightW'(ResetHeight);
      fail_count        = 0;
      requests_sent     = 0;
      responses_checked = 0;
      blurs_expected    = 0;
      config_writes     = 0;
      quiet_cycles      = 0;
      hold_request      = 1'b0;
      hold_active       = 1'b0;
   end

   // Mirror a register write; either geometry register restarts the frame
   function automatic void apply_csr(input logic [CsrIdxW-1:0] idx,
                                     input logic [CsrDataW-1:0] data);
      if (idx == CsrFrameWidth) begin
         width_reg = data[CfgWidthW-1:0];
         next_row  = 0;
         next_col  = 0;
      end else if (idx == CsrFrameHeight) begin
         height_reg = data[CfgHeightW-1:0];
         next_row   = 0;
         next_col   = 0;
      end
   endfunction

   // Work out the responses of one accepted pixel and queue them in order:
   // the blurred upper-left neighbor first, then the pixel's own border value
   function automatic void predict_pixel(input logic [PixW-1:0] blue,
                                         input logic [PixW-1:0] green,
                                         input logic [PixW-1:0] red);
      int unsigned      w;
      int unsigned      h;
      int unsigned      r;
      int unsigned      c;
      int unsigned      gray;
      int unsigned      sum;
      bit               has_blur;
      bit               has_border;
      pixel_result_type item;

      w = (width_reg == 0) ? 1 : ((width_reg > MaxWidth) ? MaxWidth : width_reg);
      h = (height_reg == 0) ? 1 : height_reg;
      r = next_row;
      c = next_col;
      if (c >= w) c = 0;
      if (r >= h) r = 0;

      gray = (RedWt * red + GreenWt * green + BlueWt * blue) / 100;

      window_col[0] = window_col[1];
      window_col[1] = window_col[2];
      window_col[2] = {gray_two_rows_up[c], gray_one_row_up[c], PixW'(gray)};
      gray_two_rows_up[c] = gray_one_row_up[c];
      gray_one_row_up[c]  = PixW'(gray);

      has_blur   = (r >= 2) && (c >= 2);
      has_border = (r == 0) || (r == h - 1) || (c == 0) || (c == w - 1);

      if (has_blur) begin
         sum = 0;
         for (int i = 0; i < 3; i++)
            sum += window_col[i][7:0] + window_col[i][15:8] + window_col[i][23:16];
         item.gray = PixW'(sum / 9);
         item.row  = RowW'(r - 1);
         item.col  = ColW'(c - 1);
         item.last = !has_border;
         expected_q.push_back(item);
         blurs_expected++;
      end
      if (has_border) begin
         item.gray = PixW'(gray);
         item.row  = RowW'(r);
         item.col  = ColW'(c);
         item.last = 1'b1;
         expected_q.push_back(item);
      end

      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      next_row = r;
      next_col = c;
   endfunction

   task automatic report_error(input string msg);
      $display("[%0t] ERROR: %s", $time, msg);
      fail_count++;
   endtask

   // ------------------------------------------------------------------
   // Clock
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Monitor: check the response first, then predict the request taken
   // at the same edge. Both read the values the block itself sampled.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      pixel_result_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            responses_checked++;
            if (expected_q.size() == 0) begin
               report_error($sformatf("response with nothing expected: row %0d col %0d",
                                      rsp_out_row, rsp_out_col));
            end else begin
               want = expected_q.pop_front();
               if (rsp_gray_out !== want.gray)
                  report_error($sformatf("gray_out %0d, expected %0d (row %0d col %0d)",
                                         rsp_gray_out, want.gray, want.row, want.col));
               if (rsp_out_row !== want.row)
                  report_error($sformatf("out_row %0d, expected %0d",
                                         rsp_out_row, want.row));
               if (rsp_out_col !== want.col)
                  report_error($sformatf("out_col %0d, expected %0d",
                                         rsp_out_col, want.col));
               if (rsp_run_last !== want.last)
                  report_error($sformatf("run_last %0b, expected %0b (row %0d col %0d)",
                                         rsp_run_last, want.last, want.row, want.col));
            end
         end
         if (req_valid && req_ready) begin
            requests_sent++;
            predict_pixel(req_blue, req_green, req_red);
         end
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: give up after a long stretch with no handshake at all
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
         $display("[%0t] timeout: no handshake for %0d cycles, %0d responses pending",
                  $time, quiet_cycles, expected_q.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Receiver: alternate ready and stall stretches of random length, with
   // occasional long all-ready runs; on request, hold off for HoldCycles.
   // ------------------------------------------------------------------
   initial begin : receiver
      int unsigned len;
      bit          level;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            hold_active = 1'b1;
            repeat (HoldCycles) @(posedge clock);
            hold_active  = 1'b0;
            hold_request = 1'b0;
            rsp_ready <= 1'b1;
         end else begin
            case ($urandom_range(0, 7))
               0:       begin level = 1'b1; len = 30; end
               1, 2, 3: begin level = 1'b0; len = $urandom_range(1, 6); end
               default: begin level = 1'b1; len = $urandom_range(1, 8); end
            endcase
            rsp_ready <= level;
            repeat (len - 1) @(posedge clock);
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // Offer one pixel and hold it until accepted; returns at the accepting
   // edge with valid still high so a following request goes out back to back
   task automatic send_pixel(input logic [PixW-1:0] blue,
                             input logic [PixW-1:0] green,
                             input logic [PixW-1:0] red);
      req_valid <= 1'b1;
      req_blue  <= blue;
      req_green <= green;
      req_red   <= red;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Drop valid for a few cycles between bursts
   task automatic idle_gap(input int unsigned cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Wait until every expected response is in, then let silent pixels clear
   task automatic settle_block();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_q.size() != 0);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrIdxW-1:0] idx, input logic [CsrDataW-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      apply_csr(idx, data);
      config_writes++;
   endtask

   // Bias components toward the extremes now and then
   function automatic logic [PixW-1:0] pick_component();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return PixW'($urandom_range(0, 255));
      endcase
   endfunction

   // Random pixels in bursts of random length with random gaps in between
   task automatic stream_pixels(input int unsigned count, input bit no_gaps);
      int unsigned burst_left;
      int unsigned gap;
      burst_left = $urandom_range(1, 12);
      for (int unsigned i = 0; i < count; i++) begin
         send_pixel(pick_component(), pick_component(), pick_component());
         if (!no_gaps) begin
            burst_left--;
            if (burst_left == 0) begin
               gap = $urandom_range(0, 4);
               if (gap > 0) idle_gap(gap);
               burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
            end
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Out of reset the frame is 640x480: the first pixels are top-border pass-through
   task automatic test_default_geometry();
      send_pixel('0, '0, '0);
      send_pixel('1, '1, '1);
      settle_block();
   endtask

   // Zero width and zero height both act as one: every pixel is its own frame
   task automatic test_degenerate_sizes();
      write_reg(CsrFrameWidth, '0);
      write_reg(CsrFrameHeight, '0);
      send_pixel('0, '0, '1);
      send_pixel('0, '1, '0);
      settle_block();
   endtask

   // 3x3 frame: one blurred center, eight borders, then wrap into the next
   // frame. Halfway through, spare register writes must not restart it.
   task automatic test_full_window();
      logic [3*PixW-1:0] pix [10];
      pix = '{24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00, 24'hFFFFFF,
              24'hFF0000, 24'hAA55AA, 24'h55AA55, 24'hFFFFFF, 24'h010203};
      write_reg(CsrFrameWidth, 16'd3);
      write_reg(CsrFrameHeight, 16'd3);
      for (int i = 0; i < 10; i++) begin
         if (i == 4) begin
            settle_block();
            write_reg(CsrSpareA, '1);
            write_reg(CsrSpareB, '1);
         end
         send_pixel(pix[i][23:16], pix[i][15:8], pix[i][7:0]);
      end
      settle_block();
   endtask

   // Width beyond the line store clamps to it; full-scale register values
   task automatic test_wide_frame();
      write_reg(CsrFrameWidth, 16'h07FF);
      write_reg(CsrFrameHeight, 16'hFFFF);
      send_pixel(8'hAA, 8'h55, 8'hAA);
      send_pixel(8'h55, 8'hAA, 8'h55);
      send_pixel('1, '0, '1);
      send_pixel('0, '1, '0);
      settle_block();
   endtask

   // Hold the output off for a long stretch while requests keep coming,
   // so the queue fills and the input stalls
   task automatic test_output_backpressure();
      write_reg(CsrFrameWidth, 16'd6);
      write_reg(CsrFrameHeight, 16'd6);
      hold_request = 1'b1;
      @(posedge clock);
      while (!hold_active) @(posedge clock);
      stream_pixels(30, 1'b1);
      settle_block();
   endtask

   // Random geometry phases, mostly small frames so blurs and wraps are
   // frequent, a few wide or clamped ones, sometimes no rewrite at all
   task automatic test_random_frames(input int unsigned target);
      int unsigned sent;
      int unsigned count;
      logic [CsrDataW-1:0] w;
      logic [CsrDataW-1:0] h;
      sent = 0;
      while (sent < target) begin
         case ($urandom_range(0, 9))
            0:       begin w = CsrDataW'($urandom_range(1000, 2047));
                           h = CsrDataW'($urandom_range(0, 4)); end
            1:       begin w = CsrDataW'($urandom_range(0, 2));
                           h = CsrDataW'($urandom_range(0, 65535)); end
            default: begin w = CsrDataW'($urandom_range(3, 7));
                           h = CsrDataW'($urandom_range(2, 6)); end
         endcase
         case ($urandom_range(0, 5))
            0:       write_reg(CsrFrameWidth, w);
            1:       write_reg(CsrFrameHeight, h);
            2:       ;  // keep going in the current frame
            default: begin
               write_reg(CsrFrameWidth, w);
               write_reg(CsrFrameHeight, h);
            end
         endcase
         count = $urandom_range(8, 30);
         stream_pixels(count, 1'b0);
         sent += count;
         settle_block();
      end
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      reset     = 1'b1;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_blue  = '0;
      req_green = '0;
      req_red   = '0;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_geometry();
      test_degenerate_sizes();
      test_full_window();
      test_wide_frame();
      test_output_backpressure();
      test_random_frames(50);

      settle_block();
      $display("Run covered %0d pixel requests over %0d register writes: degenerate,",
               requests_sent, config_writes);
      $display("3x3, clamped wide and random small frames, %0d responses (%0d blurred).",
               responses_checked, blurs_expected);
      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
